/* rtl/ddms_pkg.sv */
// Shared types, constants and helpers for the duplicate detector.
// No dependencies; every other file of the block but ddms_out_if and ddms_ram uses this package.
`default_nettype none

package ddms_pkg;

  // Store capacity and derived widths
  localparam int MAX_ELEMENTS = 64;
  localparam int VALUE_W      = 32;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int JOB_DEPTH    = 2;

  // One finished set, handed from the loader to the sorter
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             overflow;
  } job_t;

  // Write request from the loader into the first bank
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } load_req_t;

  // Memory request from the sorter into both banks
  typedef struct packed {
    logic               we;
    logic               wbank;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic               rbank;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
  } mem_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MERGE_RD,
    BK_MERGE_CMP,
    BK_SCAN_RD,
    BK_SCAN_CMP,
    BK_EMIT
  } back_state_t;

  // Bias the sign bit so that signed order becomes unsigned order
  function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v);
    return v ^ {1'b1, {(VALUE_W-1){1'b0}}};
  endfunction

endpackage

`default_nettype wire

/* rtl/ddms_in_if.sv */
// Input channel: one set element per request, with an end-of-set mark.
// Depends on ddms_pkg for the value width.
`default_nettype none

interface ddms_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ddms_pkg::VALUE_W-1:0] value;
  logic                              is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

/* rtl/ddms_out_if.sv */
// Result channel: one request per finished set.
// No dependencies.
`default_nettype none

interface ddms_out_if;
  logic valid;
  logic ready;
  logic has_duplicate;
  logic overflow;

  modport source (output valid, output has_duplicate, output overflow, input ready);
  modport sink   (input valid, input has_duplicate, input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/duplicate_detect_merge_sort_unit.sv */
// Duplicate detector by merge sort. After the marked request, n stored
// values go through ceil(log2 n) merge passes, then an adjacent-equal scan.
// The first request of the next set is accepted once the sorter releases
// the store. Synchronous reset clears control state only; the store needs
// no clearing pass.
`default_nettype none

module duplicate_detect_merge_sort_unit (
  input wire logic clk,
  input wire logic rst,
  ddms_in_if.sink    items,
  ddms_out_if.source results
);
  import ddms_pkg::*;

  job_t               job_in;
  job_t               job_out;
  logic               job_push;
  logic               job_pop;
  logic               job_full;
  logic               job_valid;
  logic               store_release;
  load_req_t          load;
  mem_req_t           mem_req;

  logic               b0_we;
  logic [ADDR_W-1:0]  b0_waddr;
  logic [VALUE_W-1:0] b0_wdata;
  logic               b1_we;
  logic [VALUE_W-1:0] b0_rdata_a;
  logic [VALUE_W-1:0] b0_rdata_b;
  logic [VALUE_W-1:0] b1_rdata_a;
  logic [VALUE_W-1:0] b1_rdata_b;
  logic [VALUE_W-1:0] rdata_a;
  logic [VALUE_W-1:0] rdata_b;

  ddms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .items        (items),
    .job_full     (job_full),
    .store_release(store_release),
    .job_push     (job_push),
    .job          (job_in),
    .load         (load)
  );

  ddms_job_fifo u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .job_in   (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .job_out  (job_out),
    .job_valid(job_valid)
  );

  ddms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job_out),
    .job_pop      (job_pop),
    .mem_req      (mem_req),
    .rdata_a      (rdata_a),
    .rdata_b      (rdata_b),
    .store_release(store_release),
    .results      (results)
  );

  // Bank 0 is shared between loader and sorter, never at the same time
  assign b0_we    = load.we || (mem_req.we && !mem_req.wbank);
  assign b0_waddr = load.we ? load.addr : mem_req.waddr;
  assign b0_wdata = load.we ? load.data : mem_req.wdata;
  assign b1_we    = mem_req.we && mem_req.wbank;

  ddms_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_bank0 (
    .clk    (clk),
    .we     (b0_we),
    .waddr  (b0_waddr),
    .wdata  (b0_wdata),
    .raddr_a(mem_req.raddr_a),
    .raddr_b(mem_req.raddr_b),
    .rdata_a(b0_rdata_a),
    .rdata_b(b0_rdata_b)
  );

  ddms_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_bank1 (
    .clk    (clk),
    .we     (b1_we),
    .waddr  (mem_req.waddr),
    .wdata  (mem_req.wdata),
    .raddr_a(mem_req.raddr_a),
    .raddr_b(mem_req.raddr_b),
    .rdata_a(b1_rdata_a),
    .rdata_b(b1_rdata_b)
  );

  // Select the source bank of the current pass
  assign rdata_a = mem_req.rbank ? b1_rdata_a : b0_rdata_a;
  assign rdata_b = mem_req.rbank ? b1_rdata_b : b0_rdata_b;

  // Loader and sorter never write bank 0 in the same cycle
  a_bank0_owner: assert property (@(posedge clk) disable iff (rst)
    !(load.we && mem_req.we && !mem_req.wbank))
    else $error("bank 0 written by loader and sorter together");

  // No request is taken while a finished set waits in the queue
  a_load_queue_empty: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |-> !job_valid)
    else $error("request accepted while a set is queued");

  // The end of a set locks out the next request
  a_lock_after_last: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.is_last) |=> !items.ready)
    else $error("request path open right after end of set");

  // A result appears only when the sorter releases the store
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(store_release))
    else $error("result raised without store release");

endmodule

`default_nettype wire

/* rtl/ddms_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module ddms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* rtl/ddms_front.sv */
// Loader: accepts set elements, appends them to the store, counts and
// flags overflow, and hands a finished set to the sorter. Uses ddms_pkg.
`default_nettype none

module ddms_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ddms_in_if.sink            items,
  input  wire logic          job_full,
  input  wire logic          store_release,
  output logic               job_push,
  output ddms_pkg::job_t     job,
  output ddms_pkg::load_req_t load
);
  import ddms_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             accept;
  logic             room;

  // Hold off new requests while the sorter owns the store or the queue is full
  assign items.ready = !busy && !job_full;
  assign accept      = items.valid && items.ready;
  assign room        = count < CNT_W'(MAX_ELEMENTS);

  // Append the element when there is room
  assign load.we   = accept && room;
  assign load.addr = count[ADDR_W-1:0];
  assign load.data = items.value;

  // Hand over the set on the marked request
  assign job_push     = accept && items.is_last;
  assign job.count    = room ? count + CNT_W'(1) : count;
  assign job.overflow = ovf || !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (accept) begin
        if (items.is_last) begin
          busy  <= 1'b1;
          count <= '0;
          ovf   <= 1'b0;
        end else if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (store_release) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ddms_job_fifo.sv */
// Short queue of finished sets between loader and sorter.
// Uses ddms_pkg for the entry type and depth.
`default_nettype none

module ddms_job_fifo (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire ddms_pkg::job_t job_in,
  output logic           full,
  input  wire logic      pop,
  output ddms_pkg::job_t job_out,
  output logic           job_valid
);
  import ddms_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int FILL_W = $clog2(JOB_DEPTH + 1);

  job_t              entries [JOB_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full      = fill == FILL_W'(JOB_DEPTH);
  assign job_valid = fill != '0;
  assign job_out   = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ddms_back.sv */
// Sorter: bottom-up merge sort between two banks, then an adjacent-equal
// scan, then the result register. Uses ddms_pkg.
`default_nettype none

module ddms_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   job_valid,
  input  wire ddms_pkg::job_t         job,
  output logic                        job_pop,
  output ddms_pkg::mem_req_t          mem_req,
  input  wire logic [ddms_pkg::VALUE_W-1:0] rdata_a,
  input  wire logic [ddms_pkg::VALUE_W-1:0] rdata_b,
  output logic                        store_release,
  ddms_out_if.source                  results
);
  import ddms_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] w;
  logic [CNT_W-1:0] a;
  logic [CNT_W-1:0] b;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] hi;
  logic [CNT_W-1:0] k;
  logic             src;
  logic             dup;
  logic             ovf;

  logic             take_a;
  logic [CNT_W-1:0] k_inc;
  logic             pass_done;
  logic             run_done;
  logic [CNT_W:0]   w_dbl;
  logic             sorted;
  logic             scan_hit;
  logic             scan_end;
  logic             out_free;

  // Clamp a run bound to the set size
  function automatic logic [CNT_W-1:0] clamp_to(input logic [CNT_W:0]   sum,
                                                input logic [CNT_W-1:0] lim);
    if (sum > {1'b0, lim}) begin
      return lim;
    end
    return sum[CNT_W-1:0];
  endfunction

  // Merge and scan decisions
  assign take_a    = (a < mid) &&
                     ((b >= hi) || (order_key(rdata_a) <= order_key(rdata_b)));
  assign k_inc     = k + CNT_W'(1);
  assign pass_done = k_inc == n;
  assign run_done  = k_inc == hi;
  assign w_dbl     = {w, 1'b0};
  assign sorted    = w_dbl >= {1'b0, n};
  assign scan_hit  = rdata_a == rdata_b;
  assign scan_end  = (b + CNT_W'(1)) == n;
  assign out_free  = !results.valid || results.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          state_next = (job.count > CNT_W'(1)) ? BK_MERGE_RD : BK_EMIT;
        end
      end
      BK_MERGE_RD: begin
        state_next = BK_MERGE_CMP;
      end
      BK_MERGE_CMP: begin
        state_next = (pass_done && sorted) ? BK_SCAN_RD : BK_MERGE_RD;
      end
      BK_SCAN_RD: begin
        state_next = BK_SCAN_CMP;
      end
      BK_SCAN_CMP: begin
        state_next = (scan_hit || scan_end) ? BK_EMIT : BK_SCAN_RD;
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Outputs per state
  always_comb begin
    mem_req.we      = state == BK_MERGE_CMP;
    mem_req.wbank   = ~src;
    mem_req.waddr   = k[ADDR_W-1:0];
    mem_req.wdata   = take_a ? rdata_a : rdata_b;
    mem_req.rbank   = src;
    mem_req.raddr_a = a[ADDR_W-1:0];
    mem_req.raddr_b = b[ADDR_W-1:0];
    job_pop         = (state == BK_IDLE) && job_valid;
    store_release   = (state == BK_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sort and scan datapath
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          n   <= job.count;
          ovf <= job.overflow;
          w   <= CNT_W'(1);
          src <= 1'b0;
          dup <= 1'b0;
          a   <= '0;
          k   <= '0;
          mid <= clamp_to((CNT_W+1)'(1), job.count);
          b   <= clamp_to((CNT_W+1)'(1), job.count);
          hi  <= clamp_to((CNT_W+1)'(2), job.count);
        end
      end
      BK_MERGE_CMP: begin
        if (pass_done) begin
          src <= ~src;
          a   <= '0;
          k   <= '0;
          if (sorted) begin
            b <= CNT_W'(1);
          end else begin
            w   <= w_dbl[CNT_W-1:0];
            mid <= clamp_to({1'b0, w_dbl[CNT_W-1:0]}, n);
            b   <= clamp_to({1'b0, w_dbl[CNT_W-1:0]}, n);
            hi  <= clamp_to({w_dbl[CNT_W-1:0], 1'b0}, n);
          end
        end else if (run_done) begin
          k   <= k_inc;
          a   <= hi;
          mid <= clamp_to({1'b0, hi} + {1'b0, w}, n);
          b   <= clamp_to({1'b0, hi} + {1'b0, w}, n);
          hi  <= clamp_to({1'b0, hi} + w_dbl, n);
        end else begin
          k <= k_inc;
          if (take_a) begin
            a <= a + CNT_W'(1);
          end else begin
            b <= b + CNT_W'(1);
          end
        end
      end
      BK_SCAN_CMP: begin
        if (scan_hit) begin
          dup <= 1'b1;
        end else if (!scan_end) begin
          a <= b;
          b <= b + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (store_release) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_release) begin
      results.has_duplicate <= dup;
      results.overflow      <= ovf;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the merge-sort duplicate detector: drives sets of signed values,
// predicts the verdict of each set and checks every result request against it.
// Depends on ddms_pkg, ddms_in_if, ddms_out_if and duplicate_detect_merge_sort_unit.
`timescale 1ns / 1ps

module tb_top;
  import ddms_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int TARGET_ELEMENTS = 1950;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int IDLE_PERCENT    = 30;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef value_t value_q_t[$];

  typedef struct packed {
    logic has_duplicate;
    logic overflow;
  } verdict_t;

  // How the values of one random set are drawn
  typedef enum int {
    FLAVOR_WIDE,
    FLAVOR_NARROW,
    FLAVOR_EDGE
  } flavor_t;

  localparam value_t MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t MAX_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk;
  logic rst = 1'b1;

  ddms_in_if  items_if ();
  ddms_out_if results_if ();

  duplicate_detect_merge_sort_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  // Predictor state: values stored so far in the open set
  value_t   set_store[$];
  logic     set_overflow = 1'b0;
  verdict_t pending_verdicts[$];

  int     mismatch_count = 0;
  int     elements_sent  = 0;
  bit     steady_flow    = 1'b0;
  longint cycle_count    = 0;

  // Clock
  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Fold one accepted element into the open set; close the set on the mark
  function automatic void absorb_element(input value_t v, input logic last);
    verdict_t verdict;
    if (set_store.size() < MAX_ELEMENTS) set_store.push_back(v);
    else set_overflow = 1'b1;
    if (last) begin
      verdict.has_duplicate = 1'b0;
      verdict.overflow      = set_overflow;
      for (int i = 0; i < set_store.size(); i++)
        for (int j = i + 1; j < set_store.size(); j++)
          if (set_store[i] == set_store[j]) verdict.has_duplicate = 1'b1;
      pending_verdicts.push_back(verdict);
      set_store.delete();
      set_overflow = 1'b0;
    end
  endfunction

  // Result side: stall at random unless in a steady stretch
  always @(posedge clk) begin
    results_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compare each result request with the oldest pending verdict
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no set pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (results_if.has_duplicate !== want.has_duplicate)
          report_mismatch($sformatf("has_duplicate got %b want %b",
                                    results_if.has_duplicate, want.has_duplicate));
        if (results_if.overflow !== want.overflow)
          report_mismatch($sformatf("overflow got %b want %b",
                                    results_if.overflow, want.overflow));
      end
    end
  end

  // Send one element, idling the request side now and then
  task automatic send_element(input value_t v, input logic last);
    if (!steady_flow) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        items_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    items_if.valid   <= 1'b1;
    items_if.value   <= v;
    items_if.is_last <= last;
    @(posedge clk);
    while (items_if.ready !== 1'b1) @(posedge clk);
    absorb_element(v, last);
    elements_sent++;
  endtask

  task automatic send_set(input value_q_t elems);
    foreach (elems[i]) send_element(elems[i], i == elems.size() - 1);
  endtask

  function automatic value_t pick_value(input flavor_t flavor);
    value_t base;
    case (flavor)
      FLAVOR_WIDE: begin
        return value_t'($urandom());
      end
      FLAVOR_NARROW: begin
        return value_t'($urandom_range(6)) - 3;
      end
      default: begin
        // hug the signed extremes and the zero crossing, wrapping freely
        case ($urandom_range(3))
          0:       base = MIN_VALUE;
          1:       base = MAX_VALUE;
          2:       base = '0;
          default: base = '1;
        endcase
        return base + value_t'($urandom_range(4)) - 2;
      end
    endcase
  endfunction

  // Mostly small sets, some large, a few past capacity
  function automatic int pick_set_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return $urandom_range(12, 1);
    if (roll < 85) return $urandom_range(63, 13);
    if (roll < 92) return MAX_ELEMENTS;
    return $urandom_range(MAX_ELEMENTS + 8, MAX_ELEMENTS + 1);
  endfunction

  task automatic send_random_set(input int size);
    value_q_t elems;
    flavor_t  flavor;
    int       src;
    int       dst;
    flavor = flavor_t'($urandom_range(2));
    for (int i = 0; i < size; i++) elems.push_back(pick_value(flavor));
    // plant a repeat in about half of the sets
    if (size > 1 && $urandom_range(1) == 1) begin
      src = $urandom_range(size - 1);
      dst = $urandom_range(size - 1);
      elems[dst] = elems[src];
    end
    send_set(elems);
  endtask

  // One-element sets can never hold a repeat
  task automatic test_single_element();
    send_set('{MIN_VALUE});
    send_set('{MAX_VALUE});
    send_set('{value_t'(0)});
  endtask

  // Distinct extremes, including neighbors across the sign boundary
  task automatic test_extremes_distinct();
    send_set('{MAX_VALUE, MIN_VALUE, value_t'(0), value_t'(-1), value_t'(1),
               MIN_VALUE + 1, MAX_VALUE - 1});
  endtask

  // Repeats at the extremes and in the smallest set that can hold one
  task automatic test_extremes_repeat();
    send_set('{MIN_VALUE, MAX_VALUE, MIN_VALUE});
    send_set('{value_t'(-1), value_t'(0), value_t'(-1)});
    send_set('{MAX_VALUE, MAX_VALUE});
  endtask

  // Past capacity: dropped values, the marked one too, never count as repeats; stored ones still do
  task automatic test_store_overflow();
    value_q_t elems;
    for (int i = 0; i < MAX_ELEMENTS; i++) elems.push_back(value_t'(i * 7 - 200));
    elems.push_back(elems[0]);
    send_set(elems);
    elems.delete();
    for (int i = 0; i < MAX_ELEMENTS + 2; i++) elems.push_back(pick_value(FLAVOR_WIDE));
    elems[MAX_ELEMENTS - 1] = elems[3];
    send_set(elems);
  endtask

  // Random sets until the element budget is spent, with one steady stretch
  task automatic test_random_sets();
    while (elements_sent < TARGET_ELEMENTS) begin
      steady_flow = (elements_sent > 900 && elements_sent < 1200);
      send_random_set(pick_set_size());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    items_if.valid   = 1'b0;
    items_if.value   = '0;
    items_if.is_last = 1'b0;
    results_if.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_single_element();
    test_extremes_distinct();
    test_extremes_repeat();
    test_store_overflow();
    test_random_sets();

    // Drain outstanding verdicts, then watch for strays
    items_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
